// ===== design/cptt_pkg.sv =====
// ----------------------------------------------------------------------------
// cptt_pkg
// shared types and constants of the cubic point-to-point trajectory generator
// ----------------------------------------------------------------------------
`default_nettype none

package cptt_pkg;

  localparam int unsigned NUM_AXES_DEF = 3;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 22;
  localparam int unsigned POS_W        = 22;
  localparam int unsigned VEL_W        = 27;
  localparam int unsigned SCALE_W      = 17;
  localparam int unsigned RATE_W       = 21;
  localparam int unsigned DIFF_W       = 23;
  localparam int unsigned SER_STEPS    = 34;
  localparam int unsigned STEP_CNT_W   = 6;

  localparam logic signed [27:0] POS_LIM_P  = 28'sd2000000;
  localparam logic signed [27:0] POS_LIM_N  = -28'sd2000000;
  localparam logic [33:0]        VEL_POS_MX = 34'd67108863;
  localparam logic [33:0]        VEL_NEG_MX = 34'd67108864;
  localparam logic [33:0]        RATE_MX    = 34'd2097151;
  localparam logic [33:0]        SCALE_ONE  = 34'd65536;
  localparam logic [33:0]        K_VEL      = 34'd750;
  localparam logic [33:0]        K_RATE     = 34'd30000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_U,
    ST_A,
    ST_B,
    ST_SV,
    ST_GG,
    ST_R1,
    ST_R2,
    ST_P,
    ST_V1,
    ST_V2,
    ST_V3,
    ST_OUT
  } cptt_state_t;

endpackage

`default_nettype wire

// ===== design/cubic_point_to_point_trajectory_top.sv =====
// ----------------------------------------------------------------------------
// cubic_point_to_point_trajectory_top
// three-axis rest-to-rest cubic trajectory with quintic progress and its rate
// ----------------------------------------------------------------------------
// Each input item (restart flag in tuser, period in tdata) produces one result
// item with per-axis position and velocity, the quintic scale, its rate and a
// done flag. All products and quotients run through one shift-add multiplier
// and one restoring divider that handle one bit per cycle; each operation has
// a load step and then shift steps. States run U, A, B, SV, GG, R1, R2, then
// P, V1, V2, V3 per axis; the input is taken again once the previous item has
// been handed to the output register. Registers are to be written over the
// cfg channel while the block is idle; the block itself does not enforce it.
`default_nettype none

module cubic_point_to_point_trajectory_top #(
  parameter int unsigned NUM_AXES = cptt_pkg::NUM_AXES_DEF,
  parameter int unsigned OUT_W    = ((NUM_AXES * 49 + 39 + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // period_ms
  input  wire logic                           in_tuser,   // restart
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // pos per axis, vel per axis, path_scale, path_rate, done_res
  output logic [OUT_W-1:0]                    out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cptt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cptt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cptt_pkg::*;

  localparam int unsigned AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  cptt_state_t state_r, state_nxt;
  logic busy_r, busy_nxt;
  logic [STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AXW-1:0] ax_r, ax_nxt;

  logic signed [POS_W-1:0] start_r [NUM_AXES];
  logic signed [POS_W-1:0] start_nxt [NUM_AXES];
  logic signed [POS_W-1:0] end_r [NUM_AXES];
  logic signed [POS_W-1:0] end_nxt [NUM_AXES];
  logic signed [DIFF_W-1:0] d_r [NUM_AXES];
  logic signed [DIFF_W-1:0] d_nxt [NUM_AXES];
  logic signed [POS_W-1:0] pos_r [NUM_AXES];
  logic signed [POS_W-1:0] pos_nxt [NUM_AXES];
  logic signed [VEL_W-1:0] vel_r [NUM_AXES];
  logic signed [VEL_W-1:0] vel_nxt [NUM_AXES];

  logic [15:0] dur_r, dur_nxt, settle_r, settle_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [16:0] u_r, u_nxt;
  logic [32:0] a_r, a_nxt, b_r, b_nxt;
  logic [30:0] g_r, g_nxt;
  logic [20:0] inner_r, inner_nxt;
  logic [SCALE_W-1:0] sv_r, sv_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [63:0] tmp_r, tmp_nxt;

  logic [63:0] mcand_r, mcand_nxt, prod_r, prod_nxt, prod_s;
  logic [33:0] mplier_r, mplier_nxt;
  logic [15:0] rem_r, rem_nxt, rem_s;
  logic [33:0] quo_r, quo_nxt, quo_s;

  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [15:0] t_dur;
  logic [16:0] lim;
  logic [15:0] t_cur;
  logic [16:0] r2;
  logic [17:0] e_sum;
  logic [34:0] kval;
  logic signed [DIFF_W-1:0] d_cur;
  logic dneg;
  logic [DIFF_W-1:0] dmag;
  logic [37:0] inner38;
  logic [32:0] g33;
  logic [63:0] sv_sum;
  logic [24:0] off;
  logic signed [27:0] soff, psum;

  assign t_dur = (dur_r == 16'd0) ? 16'd1 : dur_r;
  assign lim = {1'b0, t_dur} + {1'b0, settle_r};
  assign t_cur = (elapsed_r < {1'b0, t_dur}) ? elapsed_r[15:0] : t_dur;
  assign d_cur = d_r[ax_r];
  assign dneg = d_cur[DIFF_W-1];
  assign dmag = dneg ? DIFF_W'(-d_cur) : DIFF_W'(d_cur);
  assign kval = ({2'b0, a_r} << 1) + {2'b0, a_r} - ({2'b0, b_r} << 1);
  assign inner38 = ({5'b0, a_r} << 2) + ({5'b0, a_r} << 1) + (38'd10 << 32)
                 - ({21'b0, u_r} << 20) + ({21'b0, u_r} << 16);
  assign g33 = {u_r[16:0], 16'b0} - a_r;

  // one bit of each serial unit per cycle
  assign prod_s = mplier_r[0] ? prod_r + mcand_r : prod_r;
  assign r2 = {rem_r, quo_r[33]};
  assign rem_s = (r2 >= {1'b0, t_dur}) ? 16'(r2 - {1'b0, t_dur}) : r2[15:0];
  assign quo_s = {quo_r[32:0], (r2 >= {1'b0, t_dur})};

  assign sv_sum = prod_s + 64'h8000_0000;
  assign off = prod_s[56:32];
  assign soff = dneg ? -$signed({3'b0, off}) : $signed({3'b0, off});
  assign psum = 28'(start_r[ax_r]) + soff;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    state_nxt = state_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    ax_nxt = ax_r;
    start_nxt = start_r;
    end_nxt = end_r;
    d_nxt = d_r;
    pos_nxt = pos_r;
    vel_nxt = vel_r;
    dur_nxt = dur_r;
    settle_nxt = settle_r;
    elapsed_nxt = elapsed_r;
    u_nxt = u_r;
    a_nxt = a_r;
    b_nxt = b_r;
    g_nxt = g_r;
    inner_nxt = inner_r;
    sv_nxt = sv_r;
    rate_nxt = rate_r;
    tmp_nxt = tmp_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt = prod_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    e_sum = {1'b0, elapsed_r} + {14'b0, in_tdata[3:0]};

    if (cfg_valid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) start_nxt[i] = cfg_data;
        if (cfg_index == CFG_IDX_W'(NUM_AXES + i)) end_nxt[i] = cfg_data;
      end
      if (cfg_index == CFG_IDX_W'(2 * NUM_AXES)) dur_nxt = cfg_data[15:0];
      if (cfg_index == CFG_IDX_W'(2 * NUM_AXES + 1)) settle_nxt = cfg_data[15:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            elapsed_nxt = 17'd0;
            for (int i = 0; i < NUM_AXES; i++) begin
              d_nxt[i] = DIFF_W'(end_r[i]) - DIFF_W'(start_r[i]);
            end
          end else begin
            elapsed_nxt = (e_sum > {1'b0, lim}) ? lim : e_sum[16:0];
          end
          busy_nxt = 1'b0;
          ax_nxt = '0;
          state_nxt = ST_U;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = '0;
          for (int i = 0; i < NUM_AXES; i++) begin
            out_data_nxt[i*POS_W +: POS_W] = pos_r[i];
            out_data_nxt[NUM_AXES*POS_W + i*VEL_W +: VEL_W] = vel_r[i];
          end
          out_data_nxt[NUM_AXES*49 +: SCALE_W] = sv_r;
          out_data_nxt[NUM_AXES*49+SCALE_W +: RATE_W] = rate_r;
          out_data_nxt[NUM_AXES*49+SCALE_W+RATE_W] = (elapsed_r >= lim);
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        if (!busy_r) begin
          busy_nxt = 1'b1;
          cnt_nxt = '0;
          prod_nxt = '0;
          rem_nxt = '0;
          unique case (state_r)
            ST_U:  quo_nxt = {2'b0, t_cur, 16'b0};
            ST_A:  begin mcand_nxt = 64'(u_r); mplier_nxt = 34'(u_r); end
            ST_B:  begin mcand_nxt = 64'(a_r); mplier_nxt = 34'(u_r); end
            ST_SV: begin mcand_nxt = 64'(b_r); mplier_nxt = 34'(inner_r); end
            ST_GG: begin mcand_nxt = 64'(g_r); mplier_nxt = 34'(g_r); end
            ST_R1: begin mcand_nxt = tmp_r; mplier_nxt = K_RATE; end
            ST_R2: quo_nxt = {2'b0, tmp_r[63:32]};
            ST_P:  begin mcand_nxt = 64'(kval); mplier_nxt = 34'(dmag); end
            ST_V1: begin mcand_nxt = 64'(g_r); mplier_nxt = 34'(dmag); end
            ST_V2: begin mcand_nxt = tmp_r; mplier_nxt = K_VEL; end
            ST_V3: quo_nxt = tmp_r[62:29];
            default: quo_nxt = quo_r;
          endcase
        end else begin
          prod_nxt = prod_s;
          mcand_nxt = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
          rem_nxt = rem_s;
          quo_nxt = quo_s;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == STEP_CNT_W'(SER_STEPS - 1)) begin
            busy_nxt = 1'b0;
            unique case (state_r)
              ST_U: begin u_nxt = quo_s[16:0]; state_nxt = ST_A; end
              ST_A: begin a_nxt = prod_s[32:0]; state_nxt = ST_B; end
              ST_B: begin
                b_nxt = prod_s[48:16];
                g_nxt = g33[30:0];
                inner_nxt = inner38[36:16];
                state_nxt = ST_SV;
              end
              ST_SV: begin
                sv_nxt = (sv_sum[63:32] > 32'(SCALE_ONE)) ? SCALE_ONE[16:0]
                                                          : sv_sum[48:32];
                state_nxt = ST_GG;
              end
              ST_GG: begin tmp_nxt = {16'b0, prod_s[63:16]}; state_nxt = ST_R1; end
              ST_R1: begin
                tmp_nxt = prod_s + {17'b0, t_dur, 31'b0};
                state_nxt = ST_R2;
              end
              ST_R2: begin
                rate_nxt = (quo_s > RATE_MX) ? RATE_MX[20:0] : quo_s[20:0];
                state_nxt = ST_P;
              end
              ST_P: begin
                if (psum > POS_LIM_P) pos_nxt[ax_r] = POS_W'(POS_LIM_P);
                else if (psum < POS_LIM_N) pos_nxt[ax_r] = POS_W'(POS_LIM_N);
                else pos_nxt[ax_r] = psum[POS_W-1:0];
                state_nxt = ST_V1;
              end
              ST_V1: begin tmp_nxt = prod_s; state_nxt = ST_V2; end
              ST_V2: begin tmp_nxt = prod_s; state_nxt = ST_V3; end
              ST_V3: begin
                if (dneg) begin
                  vel_nxt[ax_r] = (quo_s > VEL_NEG_MX) ? VEL_W'(-VEL_NEG_MX)
                                                       : VEL_W'(-quo_s);
                end else begin
                  vel_nxt[ax_r] = (quo_s > VEL_POS_MX) ? VEL_POS_MX[VEL_W-1:0]
                                                       : quo_s[VEL_W-1:0];
                end
                if (ax_r == AXW'(NUM_AXES - 1)) begin
                  state_nxt = ST_OUT;
                end else begin
                  ax_nxt = ax_r + 1'b1;
                  state_nxt = ST_P;
                end
              end
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= 1'b0;
      cnt_r <= '0;
      ax_r <= '0;
      dur_r <= 16'd10000;
      settle_r <= 16'd0;
      elapsed_r <= 17'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        start_r[i] <= '0;
        end_r[i] <= '0;
        d_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      ax_r <= ax_nxt;
      dur_r <= dur_nxt;
      settle_r <= settle_nxt;
      elapsed_r <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      start_r <= start_nxt;
      end_r <= end_nxt;
      d_r <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    vel_r <= vel_nxt;
    u_r <= u_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    g_r <= g_nxt;
    inner_r <= inner_nxt;
    sv_r <= sv_nxt;
    rate_r <= rate_nxt;
    tmp_r <= tmp_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r <= prod_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/cubic_point_to_point_trajectory_top_test.sv =====
// ----------------------------------------------------------------------------
// cubic_point_to_point_trajectory_top_test
// self-checking bench for the three-axis cubic trajectory generator
// ----------------------------------------------------------------------------
// A directed table covers the reset state, the range extremes, out-of-range
// starts, zero and tiny durations and the settle hold. Random phases follow:
// each sets new registers while idle, then streams restart and tick items in
// bursts. Every result is compared with a local fixed-point predictor.
`default_nettype none

module cubic_point_to_point_trajectory_top_test;
  import cptt_pkg::*;

  localparam int AXES = NUM_AXES_DEF;
  localparam int OUT_BITS = ((AXES * 49 + 39 + 7) / 8) * 8;
  localparam int TARGET_ITEMS = 1450;
  localparam longint TWO32 = 64'sh1_0000_0000;

  localparam logic [3:0] REG_START_X  = 4'd0;
  localparam logic [3:0] REG_END_X    = 4'd3;
  localparam logic [3:0] REG_DURATION = 4'd6;
  localparam logic [3:0] REG_SETTLE   = 4'd7;
  localparam int         REG_COUNT    = 8;
  localparam logic [3:0] REG_UNUSED   = 4'd11;

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0] pos;
    logic [AXES-1:0][VEL_W-1:0] vel;
    logic [SCALE_W-1:0]         scale;
    logic [RATE_W-1:0]          rate;
    logic                       done;
  } traj_res_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [3:0] idx;
    logic [21:0] data;
    bit         restart;
    logic [3:0] period;
    bit         known;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;  // period_ms
  logic in_tuser = 1'b0;      // restart
  logic out_tvalid;
  logic out_tready = 1'b0;
  // pos per axis, vel per axis, path_scale, path_rate, done_res
  logic [OUT_BITS-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cubic_point_to_point_trajectory_top uut (.*);

  always #4 clk = ~clk;

  longint start_q[AXES], end_q[AXES], quad_q[AXES], cubic_q[AXES];
  longint unsigned dur_q = 10000, settle_q = 0, elapsed_q = 0;
  traj_res_t traj_q[$];
  bit item_known = 1'b0;
  int err_cnt = 0;
  int sent = 0;
  int burst_left = 0;

  initial begin
    for (int i = 0; i < AXES; i++) begin
      start_q[i] = 0; end_q[i] = 0; quad_q[i] = 0; cubic_q[i] = 0;
    end
  end

  function automatic traj_res_t predict_sample(bit rs, logic [3:0] per);
    longint unsigned tt, lim, t, u, a2, b3, inner, sval, g, g2, den, rate, e;
    longint num, p, vn, v;
    traj_res_t r;
    tt = (dur_q == 0) ? 1 : dur_q;
    lim = tt + settle_q;
    if (rs) begin
      elapsed_q = 0;
      for (int i = 0; i < AXES; i++) begin
        quad_q[i] = 3 * (end_q[i] - start_q[i]);
        cubic_q[i] = -2 * (end_q[i] - start_q[i]);
      end
    end else begin
      e = elapsed_q + per;
      if (e > lim) e = lim;
      elapsed_q = e & 64'h1FFFF;
    end
    t = (elapsed_q < tt) ? elapsed_q : tt;
    u = (t << 16) / tt;
    a2 = u * u;
    b3 = (a2 * u) >> 16;
    for (int i = 0; i < AXES; i++) begin
      num = quad_q[i] * longint'(a2) + cubic_q[i] * longint'(b3);
      p = start_q[i] + num / TWO32;
      vn = 2 * quad_q[i] * longint'(u << 16) + 3 * cubic_q[i] * longint'(a2);
      v = (vn * 125) / longint'(tt << 29);
      if (p > 2000000) p = 2000000;
      if (p < -2000000) p = -2000000;
      if (v > 67108863) v = 67108863;
      if (v < -67108864) v = -67108864;
      r.pos[i] = p[POS_W-1:0];
      r.vel[i] = v[VEL_W-1:0];
    end
    inner = (6 * a2 + (64'd10 << 32) - 15 * (u << 16)) >> 16;
    sval = (b3 * inner + 64'h8000_0000) >> 32;
    if (sval > 65536) sval = 65536;
    g = u * (65536 - u);
    g2 = (g * g) >> 16;
    den = tt << 32;
    rate = (g2 * 30000 + den / 2) / den;
    if (rate > 2097151) rate = 2097151;
    r.scale = sval[SCALE_W-1:0];
    r.rate = rate[RATE_W-1:0];
    r.done = (elapsed_q >= lim);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // predictor runs on accepted items and register writes
  always @(posedge clk) begin
    traj_res_t r;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index < REG_END_X)
        start_q[cfg_index] = longint'($signed(cfg_data));
      else if (cfg_index < REG_DURATION)
        end_q[cfg_index - REG_END_X] = longint'($signed(cfg_data));
      else if (cfg_index == REG_DURATION)
        dur_q = cfg_data[15:0];
      else if (cfg_index == REG_SETTLE)
        settle_q = cfg_data[15:0];
    end
    if (rst_n && in_tvalid && in_tready) begin
      r = predict_sample(in_tuser, in_tdata[3:0]);
      // after reset every field is zero
      if (item_known) r = '0;
      traj_q.push_back(r);
    end
  end

  always @(posedge clk) begin
    traj_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(traj_res_t)-1:0];
      got.done = out_tdata[185];
      for (int i = 0; i < AXES; i++) begin
        got.pos[i] = out_tdata[i*POS_W +: POS_W];
        got.vel[i] = out_tdata[AXES*POS_W + i*VEL_W +: VEL_W];
      end
      got.scale = out_tdata[AXES*(POS_W+VEL_W) +: SCALE_W];
      got.rate = out_tdata[AXES*(POS_W+VEL_W) + SCALE_W +: RATE_W];
      if (traj_q.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = traj_q.pop_front();
        for (int i = 0; i < AXES; i++) begin
          if (got.pos[i] !== want.pos[i])
            report_mismatch($sformatf("pos[%0d]", i), $signed(got.pos[i]), $signed(want.pos[i]));
          if (got.vel[i] !== want.vel[i])
            report_mismatch($sformatf("vel[%0d]", i), $signed(got.vel[i]), $signed(want.vel[i]));
        end
        if (got.scale !== want.scale) report_mismatch("path_scale", got.scale, want.scale);
        if (got.rate !== want.rate) report_mismatch("path_rate", got.rate, want.rate);
        if (got.done !== want.done) report_mismatch("done_res", got.done, want.done);
      end
    end
  end

  // receiver stall pattern
  int rdy_pct = 100;
  int rdy_cnt = 0;
  always @(posedge clk) begin
    rdy_cnt <= rdy_cnt + 1;
    if (rdy_cnt % 2000 == 0) begin
      case ($urandom_range(0, 3))
        0: rdy_pct <= 100;
        1: rdy_pct <= 70;
        2: rdy_pct <= 30;
        default: rdy_pct <= 5;
      endcase
    end
    out_tready <= ($urandom_range(0, 99) < rdy_pct);
  end

  task automatic send_item(bit rs, logic [3:0] per, bit kn);
    in_tvalid <= 1'b1;
    in_tuser <= rs;
    in_tdata <= {4'b0, per};
    item_known <= kn;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_bursty(bit rs, logic [3:0] per);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 9) > 2) repeat ($urandom_range(1, 40)) @(posedge clk);
      else @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(rs, per, 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (traj_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [21:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [21:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 22'h1FFFFF;
      1: return 22'h200000;
      2: return 22'(2000000);
      3: return 22'(-2000000);
      4: return '0;
      default: return 22'($urandom());
    endcase
  endfunction

  row_t dir_rows[$];

  initial begin
    int n_phase, rd;
    bit pause_done;
    row_t rw;
    dir_rows = '{
      '{ROW_ITEM, 0, 0, 0, 4'd0, 1}, '{ROW_ITEM, 0, 0, 1, 4'd15, 1},
      '{ROW_CFG, REG_START_X, 22'h1FFFFF, 0, 0, 0},
      '{ROW_CFG, 4'd1, 22'h200000, 0, 0, 0},
      '{ROW_CFG, 4'd2, 22'd0, 0, 0, 0},
      '{ROW_CFG, REG_END_X, 22'(-2000000), 0, 0, 0},
      '{ROW_CFG, 4'd4, 22'(2000000), 0, 0, 0},
      '{ROW_CFG, 4'd5, 22'h1FFFFF, 0, 0, 0},
      '{ROW_CFG, REG_DURATION, 22'd100, 0, 0, 0},
      '{ROW_CFG, REG_SETTLE, 22'd3, 0, 0, 0},
      '{ROW_CFG, REG_UNUSED, 22'h3FFFFF, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 1, 4'd7, 0}, '{ROW_ITEM, 0, 0, 0, 4'd15, 0},
      '{ROW_ITEM, 0, 0, 0, 4'd15, 0}, '{ROW_ITEM, 0, 0, 0, 4'd15, 0},
      '{ROW_ITEM, 0, 0, 0, 4'd15, 0}, '{ROW_ITEM, 0, 0, 0, 4'd15, 0},
      '{ROW_ITEM, 0, 0, 0, 4'd15, 0}, '{ROW_ITEM, 0, 0, 0, 4'd15, 0},
      '{ROW_ITEM, 0, 0, 0, 4'd0, 0},
      '{ROW_CFG, REG_DURATION, 22'd0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 1, 4'd0, 0}, '{ROW_ITEM, 0, 0, 0, 4'd1, 0},
      '{ROW_CFG, REG_DURATION, 22'd2, 0, 0, 0},
      '{ROW_CFG, REG_SETTLE, 22'hFFFF, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 1, 4'd0, 0}, '{ROW_ITEM, 0, 0, 0, 4'd1, 0},
      '{ROW_ITEM, 0, 0, 0, 4'd15, 0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[k]) begin
      rw = dir_rows[k];
      if (rw.kind == ROW_CFG) begin
        wait_drained();
        write_reg(rw.idx, rw.data);
        close_cfg();
      end else begin
        send_item(rw.restart, rw.period, rw.known);
      end
    end
    while (sent < TARGET_ITEMS) begin
      wait_drained();
      for (int r = 0; r < AXES; r++) write_reg(4'(REG_START_X + r), rand_pos());
      for (int r = 0; r < AXES; r++) write_reg(4'(REG_END_X + r), rand_pos());
      case ($urandom_range(0, 9))
        0: write_reg(REG_DURATION, 22'd0);
        1: write_reg(REG_DURATION, 22'hFFFF);
        2: write_reg(REG_DURATION, 22'($urandom_range(1, 99)));
        default: write_reg(REG_DURATION, 22'($urandom_range(100, 600)));
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(REG_SETTLE, 22'hFFFF);
        1: write_reg(REG_SETTLE, 22'd0);
        default: write_reg(REG_SETTLE, 22'($urandom_range(0, 40)));
      endcase
      if ($urandom_range(0, 1)) write_reg(4'($urandom_range(REG_COUNT, 15)), 22'($urandom()));
      close_cfg();
      n_phase = $urandom_range(40, 120);
      pause_done = 1'b0;
      for (int k = 0; k < n_phase; k++) begin
        if (!pause_done && k > 10 && $urandom_range(0, 19) == 0) begin
          wait_drained();
          pause_done = 1'b1;
        end
        rd = $urandom_range(0, 99);
        if (k == 0) send_bursty(rd < 85, 4'($urandom()));
        else send_bursty(rd < 3, 4'($urandom()));
      end
    end
    wait_drained();
    repeat (700) @(posedge clk);
    if (err_cnt == 0 && traj_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #48000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
